[hw/rtl/ltpe_pkg.sv]
// ----------------------------------------------------------------------------
// ltpe_pkg
// shared types, command and phase codes, and the hue wheel for the twinkle
// pixel engine
// ----------------------------------------------------------------------------
package ltpe_pkg;

   localparam int LED_COUNT_DEFAULT = 256;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [1:0] CMD_INIT_PIXEL = 2'd0;
   localparam logic [1:0] CMD_ADD_ACTIVE = 2'd1;
   localparam logic [1:0] CMD_STEP_PIXEL = 2'd2;

   localparam logic [1:0] PH_IDLE      = 2'd0;
   localparam logic [1:0] PH_RISING    = 2'd1;
   localparam logic [1:0] PH_FALLING   = 2'd2;
   localparam logic [1:0] PH_RETURNING = 2'd3;

   localparam logic [1:0] CSR_NORMAL_BRIGHTNESS = 2'd0;
   localparam logic [1:0] CSR_MAX_ACTIVE        = 2'd1;

   localparam logic [7:0] WHEEL_RED = 8'd0;
   localparam logic [7:0] WHEEL_ORG = 8'd32;
   localparam logic [7:0] WHEEL_YEL = 8'd64;
   localparam logic [7:0] WHEEL_GRN = 8'd96;
   localparam logic [7:0] WHEEL_BLU = 8'd160;
   localparam logic [7:0] WHEEL_PUR = 8'd192;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] pixel_index;
      logic [2:0] hue_choice;
   } req_word_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic [1:0] phase;
      logic       accepted;
      logic [8:0] active_count;
   } rsp_word_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       in_range;
      logic [1:0] command;
      logic [7:0] pixel_index;
      logic [7:0] wheel_hue;
   } op_word_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } pixel_word_type;

   function automatic logic [7:0] wheel_hue(input logic [2:0] choice);
      logic [7:0] h;
      case (choice)
         3'd0:    h = WHEEL_RED;
         3'd1:    h = WHEEL_YEL;
         3'd2:    h = WHEEL_BLU;
         3'd3:    h = WHEEL_GRN;
         3'd4:    h = WHEEL_PUR;
         3'd5:    h = WHEEL_ORG;
         3'd6:    h = WHEEL_RED;
         default: h = WHEEL_YEL;
      endcase
      return h;
   endfunction

endpackage

[hw/rtl/ltpe_fifo.sv]
// ----------------------------------------------------------------------------
// ltpe_fifo
// small first-in first-out queue of words with full and empty flags
// ----------------------------------------------------------------------------
module ltpe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/ltpe_front.sv]
// ----------------------------------------------------------------------------
// ltpe_front
// accepts request words, checks the pixel index against the led count,
// looks up the wheel hue and queues the classified word for the back end
// ----------------------------------------------------------------------------
module ltpe_front
   import ltpe_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         hold,
   input  logic         req_push,
   input  req_word_type req_data,
   output logic         req_full,
   input  logic         op_pop,
   output op_word_type  op_word,
   output logic         op_empty
);

   localparam int AW = $clog2(LED_COUNT);
   localparam int IW = (AW > 8) ? AW : 8;

   op_word_type       class_word;
   logic [IW:0]       idx_ext;
   logic              queue_full;
   logic [$bits(op_word_type)-1:0] pop_bits;

   assign idx_ext = (IW + 1)'(req_data.pixel_index);

   always_comb begin
      class_word.in_range    = (idx_ext < (IW + 1)'(LED_COUNT));
      class_word.command     = req_data.command;
      class_word.pixel_index = req_data.pixel_index;
      class_word.wheel_hue   = wheel_hue(req_data.hue_choice);
   end

   assign req_full = queue_full || hold;
   assign op_word  = op_word_type'(pop_bits);

   ltpe_fifo #(
      .WIDTH ($bits(op_word_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !hold),
      .push_data (class_word),
      .full      (queue_full),
      .pop       (op_pop),
      .pop_data  (pop_bits),
      .empty     (op_empty)
   );

endmodule

[hw/rtl/ltpe_back.sv]
// ----------------------------------------------------------------------------
// ltpe_back
// pixel memory, configuration registers and the command sequencer: clears
// the memory after reset, then reads one pixel, updates it and writes it back
// ----------------------------------------------------------------------------
module ltpe_back
   import ltpe_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_wdata,
   input  op_word_type  op_word,
   input  logic         op_empty,
   output logic         op_pop,
   output logic         clearing,
   output rsp_word_type rsp_word,
   output logic         rsp_push,
   input  logic         rsp_full
);

   localparam int AW = $clog2(LED_COUNT);
   localparam int IW = (AW > 8) ? AW : 8;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   pixel_word_type pixel_mem_ff [LED_COUNT];
   pixel_word_type rd_word_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clear_ptr_ff, clear_ptr_in;
   op_word_type   op_ff;
   logic [8:0]    total_ff, total_in;
   logic [7:0]    normal_ff;
   logic [8:0]    max_active_ff;

   logic [IW-1:0]  rd_idx, wr_idx;
   logic [AW-1:0]  rd_addr, mem_waddr;
   logic           mem_we, mem_re;
   pixel_word_type mem_wdata, new_word;
   logic           acc;

   assign csr_ready = 1'b1;
   assign clearing  = (state_ff == ST_CLEAR);
   assign op_pop    = (state_ff == ST_FETCH) && !op_empty;
   assign rsp_push  = (state_ff == ST_EXEC) && !rsp_full;

   assign rd_idx  = IW'(op_word.pixel_index);
   assign wr_idx  = IW'(op_ff.pixel_index);
   assign rd_addr = rd_idx[AW-1:0];
   assign mem_re  = op_pop;

   // pixel update
   always_comb begin
      new_word = rd_word_ff;
      total_in = total_ff;
      acc      = 1'b0;
      case (op_ff.command)
         CMD_INIT_PIXEL: begin
            new_word.hue        = op_ff.wheel_hue;
            new_word.saturation = 8'd255;
            new_word.brightness = normal_ff;
         end
         CMD_ADD_ACTIVE: begin
            if (rd_word_ff.phase == PH_IDLE && total_ff < max_active_ff) begin
               new_word.phase = PH_RISING;
               total_in       = total_ff + 9'd1;
               acc            = 1'b1;
            end
         end
         CMD_STEP_PIXEL: begin
            case (rd_word_ff.phase)
               PH_RISING: begin
                  if (rd_word_ff.brightness == 8'd255 && rd_word_ff.saturation == 8'd0) begin
                     new_word.phase = PH_FALLING;
                  end else begin
                     new_word.brightness = (rd_word_ff.brightness == 8'd255) ?
                                           8'd255 : rd_word_ff.brightness + 8'd1;
                     new_word.saturation = (rd_word_ff.saturation <= 8'd2) ?
                                           8'd0 : rd_word_ff.saturation - 8'd2;
                  end
               end
               PH_FALLING: begin
                  if (rd_word_ff.brightness == 8'd0 && rd_word_ff.saturation == 8'd255) begin
                     new_word.brightness = 8'd0;
                     new_word.hue        = op_ff.wheel_hue;
                     new_word.saturation = 8'd255;
                     new_word.phase      = PH_RETURNING;
                  end else begin
                     new_word.brightness = (rd_word_ff.brightness <= 8'd4) ?
                                           8'd0 : rd_word_ff.brightness - 8'd4;
                     new_word.saturation = (rd_word_ff.saturation >= 8'd251) ?
                                           8'd255 : rd_word_ff.saturation + 8'd4;
                  end
               end
               PH_RETURNING: begin
                  if ({1'b0, rd_word_ff.brightness} + 9'd1 >= {1'b0, normal_ff}) begin
                     new_word.brightness = normal_ff;
                     new_word.phase      = PH_IDLE;
                     if (total_ff != 9'd0) begin
                        total_in = total_ff - 9'd1;
                     end
                  end else begin
                     new_word.brightness = rd_word_ff.brightness + 8'd1;
                  end
               end
               default: begin
                  new_word = rd_word_ff;
               end
            endcase
         end
         default: begin
            new_word = rd_word_ff;
         end
      endcase
      if (!op_ff.in_range) begin
         total_in = total_ff;
         acc      = 1'b0;
      end
   end

   always_comb begin
      if (op_ff.in_range) begin
         rsp_word.hue        = new_word.hue;
         rsp_word.saturation = new_word.saturation;
         rsp_word.brightness = new_word.brightness;
         rsp_word.phase      = new_word.phase;
      end else begin
         rsp_word.hue        = 8'd0;
         rsp_word.saturation = 8'd0;
         rsp_word.brightness = 8'd0;
         rsp_word.phase      = PH_IDLE;
      end
      rsp_word.accepted     = acc;
      rsp_word.active_count = total_in;
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clear_ptr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = rsp_push && op_ff.in_range;
         mem_waddr = wr_idx[AW-1:0];
         mem_wdata = new_word;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_ptr_in = clear_ptr_ff + 1'b1;
            if (clear_ptr_ff == AW'(LED_COUNT - 1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (!op_empty) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_full) begin
               state_in = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ptr_ff  <= '0;
         total_ff      <= 9'd0;
         normal_ff     <= 8'd128;
         max_active_ff <= 9'd64;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         if (rsp_push) begin
            total_ff <= total_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NORMAL_BRIGHTNESS: normal_ff     <= csr_wdata[7:0];
               CSR_MAX_ACTIVE:        max_active_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         op_ff <= op_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= pixel_mem_ff[rd_addr];
      end
   end

endmodule

[hw/rtl/led_twinkle_pixel_engine_unit.sv]
// ----------------------------------------------------------------------------
// led_twinkle_pixel_engine_unit
// After reset the pixel memory is cleared, and req_full stays high while
// it is; configuration writes are taken at any time. Each request word then
// yields one response word. A two-entry queue holds classified requests,
// and the back end handles each in two steps: it reads the pixel memory,
// then updates the pixel and writes it back, and it does not read the next
// request until that write-back is done. A response can be popped once its
// request has passed the request queue, both steps and the response queue.
// Responses wait in a two-entry queue until popped.
// ----------------------------------------------------------------------------
module led_twinkle_pixel_engine_unit
   import ltpe_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_word_type req_data,
   output logic         req_full,
   input  logic         rsp_pop,
   output rsp_word_type rsp_data,
   output logic         rsp_empty,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_wdata
);

   op_word_type  op_word;
   logic         op_empty, op_pop;
   logic         clearing;
   rsp_word_type rsp_word;
   logic         rsp_push, rsp_full;
   logic [$bits(rsp_word_type)-1:0] rsp_bits;

   assign rsp_data = rsp_word_type'(rsp_bits);

   ltpe_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_pop   (op_pop),
      .op_word  (op_word),
      .op_empty (op_empty)
   );

   ltpe_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_word   (op_word),
      .op_empty  (op_empty),
      .op_pop    (op_pop),
      .clearing  (clearing),
      .rsp_word  (rsp_word),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   ltpe_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_word),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for led_twinkle_pixel_engine_unit. A pending-command queue feeds
// a clocked driver, and a clocked monitor keeps its own model of the pixel
// store, predicts the response word for each accepted command and checks
// each popped word against the oldest prediction. A short directed part is
// followed by several register settings, each with random twinkle traffic
// that is mostly step commands on two pixels, so whole twinkles get
// through. Both sides idle at random, and the response side holds off once
// for a long time so that the unit backs up.
// ----------------------------------------------------------------------------
module tb;
   import ltpe_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 2000;
   localparam int         PHASE_WORDS = 265;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   req_word_type req_data = '0;
   logic         req_full;
   logic         rsp_pop = 1'b0;
   rsp_word_type rsp_data;
   logic         rsp_empty;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [8:0]   csr_wdata = '0;

   led_twinkle_pixel_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // pixel store as the unit should hold it
   logic [7:0] hue_store [256];
   logic [7:0] sat_store [256];
   logic [7:0] val_store [256];
   logic [1:0] phase_store [256];
   logic [8:0] twinkling;
   logic [7:0] rest_level;
   logic [8:0] twinkle_limit;
   logic [7:0] wheel_table [8] = '{WHEEL_RED, WHEEL_YEL, WHEEL_BLU, WHEEL_GRN,
                                   WHEEL_PUR, WHEEL_ORG, WHEEL_RED, WHEEL_YEL};

   req_word_type commands_pending [$];
   rsp_word_type pixel_reports_due [$];
   bit           colour_written [256];
   int           words_pushed = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   int           hold_cycles = 0;
   bit           hold_done = 1'b0;
   logic [7:0]   hot_a, hot_b;
   logic         calm;

   assign calm = (words_pushed >= 700) && (words_pushed < 900);

   initial begin
      for (int k = 0; k < 256; k++) phase_store[k] = PH_IDLE;
      twinkling     = '0;
      rest_level    = 8'd128;
      twinkle_limit = 9'd64;
   end

   function automatic rsp_word_type twinkle_next(input req_word_type w);
      rsp_word_type r;
      logic [7:0]   p;
      logic [8:0]   v, s;
      logic         started;
      p       = w.pixel_index;
      v       = {1'b0, val_store[p]};
      s       = {1'b0, sat_store[p]};
      started = 1'b0;
      case (w.command)
         CMD_INIT_PIXEL: begin
            hue_store[p] = wheel_table[w.hue_choice];
            sat_store[p] = 8'd255;
            val_store[p] = rest_level;
         end
         CMD_ADD_ACTIVE: begin
            if (phase_store[p] == PH_IDLE && twinkling < twinkle_limit) begin
               phase_store[p] = PH_RISING;
               twinkling      = twinkling + 9'd1;
               started        = 1'b1;
            end
         end
         CMD_STEP_PIXEL: begin
            case (phase_store[p])
               PH_RISING: begin
                  if (v == 9'd255 && s == 9'd0) begin
                     phase_store[p] = PH_FALLING;
                  end else begin
                     val_store[p] = (v >= 9'd254) ? 8'd255 : 8'(v + 9'd1);
                     sat_store[p] = (s <= 9'd2) ? 8'd0 : 8'(s - 9'd2);
                  end
               end
               PH_FALLING: begin
                  if (v == 9'd0 && s == 9'd255) begin
                     val_store[p]   = 8'd0;
                     hue_store[p]   = wheel_table[w.hue_choice];
                     sat_store[p]   = 8'd255;
                     phase_store[p] = PH_RETURNING;
                  end else begin
                     val_store[p] = (v <= 9'd4) ? 8'd0 : 8'(v - 9'd4);
                     sat_store[p] = (s >= 9'd251) ? 8'd255 : 8'(s + 9'd4);
                  end
               end
               PH_RETURNING: begin
                  if (v + 9'd1 >= {1'b0, rest_level}) begin
                     val_store[p]   = rest_level;
                     phase_store[p] = PH_IDLE;
                     if (twinkling != 9'd0) twinkling = twinkling - 9'd1;
                  end else begin
                     val_store[p] = 8'(v + 9'd1);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.hue          = hue_store[p];
      r.saturation   = sat_store[p];
      r.brightness   = val_store[p];
      r.phase        = phase_store[p];
      r.accepted     = started;
      r.active_count = twinkling;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // command driver
   always @(negedge clock) begin
      if (reset || commands_pending.size() == 0 || (!calm && $urandom_range(99) < 30)) begin
         req_push <= 1'b0;
      end else begin
         req_push <= 1'b1;
         req_data <= commands_pending[0];
      end
   end

   // response side, with one long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_pop     <= 1'b0;
      end else if (!hold_done && words_pushed >= 300) begin
         hold_cycles <= 120;
         hold_done   <= 1'b1;
         rsp_pop     <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= 30);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      bit           moved;
      moved = 1'b0;
      if (csr_valid && csr_ready) begin
         moved = 1'b1;
         if (csr_index == CSR_NORMAL_BRIGHTNESS) rest_level = csr_wdata[7:0];
         else if (csr_index == CSR_MAX_ACTIVE) twinkle_limit = csr_wdata;
      end
      if (req_push && !req_full) begin
         moved = 1'b1;
         pixel_reports_due = {pixel_reports_due, twinkle_next(req_data)};
         void'(commands_pending.pop_front());
         words_pushed++;
      end
      if (rsp_pop && !rsp_empty) begin
         moved = 1'b1;
         if (pixel_reports_due.size() == 0) begin
            $error("response word with no command waiting");
            mismatches++;
         end else begin
            want = pixel_reports_due.pop_front();
            check_field("hue", 9'(want.hue), 9'(rsp_data.hue));
            check_field("saturation", 9'(want.saturation), 9'(rsp_data.saturation));
            check_field("brightness", 9'(want.brightness), 9'(rsp_data.brightness));
            check_field("phase", 9'(want.phase), 9'(rsp_data.phase));
            check_field("accepted", 9'(want.accepted), 9'(rsp_data.accepted));
            check_field("active_count", want.active_count, rsp_data.active_count);
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic queue_command(input logic [1:0] cmd, input logic [7:0] pixel,
                                input logic [2:0] choice);
      req_word_type w;
      w.command     = cmd;
      w.pixel_index = pixel;
      w.hue_choice  = choice;
      if (cmd == CMD_INIT_PIXEL) colour_written[pixel] = 1'b1;
      commands_pending = {commands_pending, w};
   endtask

   task automatic queue_twinkle_traffic(input int count);
      int         roll;
      logic [1:0] cmd;
      logic [7:0] pixel;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 76) begin
            pixel = ($urandom_range(99) < 70) ? hot_a : hot_b;
            cmd   = (roll < 70) ? CMD_STEP_PIXEL : CMD_ADD_ACTIVE;
         end else begin
            pixel = 8'($urandom_range(255));
            cmd   = 2'($urandom_range(3));
            if (!colour_written[pixel]) cmd = CMD_INIT_PIXEL;
         end
         queue_command(cmd, pixel, 3'($urandom_range(7)));
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (commands_pending.size() == 0 && pixel_reports_due.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [7:0] levels [5];
      logic [8:0] limits [5];
      logic [7:0] level;
      logic [8:0] limit;
      levels = '{8'd0, 8'd255, 8'd128, 8'd60, 8'd0};
      limits = '{9'd256, 9'd256, 9'd0, 9'd8, 9'd0};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: wheel wrap, idle step, unused code, add limits, init mid-twinkle
      queue_command(CMD_INIT_PIXEL, 8'd0, 3'd0);
      queue_command(CMD_INIT_PIXEL, 8'd255, 3'd5);
      queue_command(CMD_INIT_PIXEL, 8'd1, 3'd6);
      queue_command(CMD_INIT_PIXEL, 8'd2, 3'd7);
      queue_command(CMD_INIT_PIXEL, 8'd3, 3'd1);
      queue_command(CMD_INIT_PIXEL, 8'd4, 3'd2);
      queue_command(CMD_INIT_PIXEL, 8'd5, 3'd3);
      queue_command(CMD_INIT_PIXEL, 8'd6, 3'd4);
      queue_command(CMD_STEP_PIXEL, 8'd0, 3'd2);
      queue_command(CMD_UNUSED, 8'd0, 3'd7);
      queue_command(CMD_ADD_ACTIVE, 8'd0, 3'd0);
      queue_command(CMD_ADD_ACTIVE, 8'd0, 3'd0);
      queue_command(CMD_STEP_PIXEL, 8'd0, 3'd1);
      queue_command(CMD_STEP_PIXEL, 8'd0, 3'd1);
      queue_command(CMD_INIT_PIXEL, 8'd0, 3'd3);
      queue_command(CMD_STEP_PIXEL, 8'd0, 3'd1);
      queue_command(CMD_ADD_ACTIVE, 8'd255, 3'd0);
      queue_command(CMD_STEP_PIXEL, 8'd255, 3'd4);
      queue_command(CMD_UNUSED, 8'd255, 3'd0);
      queue_command(CMD_ADD_ACTIVE, 8'd1, 3'd0);
      queue_command(CMD_STEP_PIXEL, 8'd2, 3'd6);
      drain();

      hot_a = 8'($urandom_range(7, 127));
      hot_b = 8'($urandom_range(128, 254));
      queue_command(CMD_INIT_PIXEL, hot_a, 3'($urandom_range(7)));
      queue_command(CMD_INIT_PIXEL, hot_b, 3'($urandom_range(7)));
      drain();

      for (int k = 0; k < 5; k++) begin
         level = levels[k];
         limit = limits[k];
         if (k == 4) begin
            level = 8'($urandom_range(255));
            limit = 9'($urandom_range(256));
         end
         write_csr(CSR_NORMAL_BRIGHTNESS, {1'b0, level});
         write_csr(CSR_MAX_ACTIVE, limit);
         queue_twinkle_traffic(PHASE_WORDS);
         drain();
      end

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/ltpe_pkg.sv
hw/rtl/ltpe_fifo.sv
hw/rtl/ltpe_front.sv
hw/rtl/ltpe_back.sv
hw/rtl/led_twinkle_pixel_engine_unit.sv
bench/tb.sv
